[hw/rtl/sic_pkg.sv]
// shared types and codes for the segment intersection classifier
package sic_pkg;

    // relation between the two segments
    typedef enum logic [2:0] {
        REL_COLLINEAR  = 3'd0,
        REL_PARALLEL   = 3'd1,
        REL_SEGMENTS   = 3'd2,
        REL_CD_CROSSES = 3'd3,
        REL_AB_CROSSES = 3'd4,
        REL_LINES_ONLY = 3'd5
    } t_relation;

endpackage

[hw/rtl/sic_if.sv]
// valid/ready channel interfaces for segment pairs and intersection results
interface sic_in_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] a_x;
    logic signed [COORD_BITS-1:0] a_y;
    logic signed [COORD_BITS-1:0] b_x;
    logic signed [COORD_BITS-1:0] b_y;
    logic signed [COORD_BITS-1:0] c_x;
    logic signed [COORD_BITS-1:0] c_y;
    logic signed [COORD_BITS-1:0] d_x;
    logic signed [COORD_BITS-1:0] d_y;

    modport source (output valid, a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y, input ready);
    modport sink   (input valid, a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y, output ready);
endinterface

interface sic_out_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    sic_pkg::t_relation           relation;
    logic signed [COORD_BITS-1:0] cross_x;
    logic signed [COORD_BITS-1:0] cross_y;
    logic                         point_clipped;

    modport source (output valid, relation, cross_x, cross_y, point_clipped, input ready);
    modport sink   (input valid, relation, cross_x, cross_y, point_clipped, output ready);
endinterface

[hw/rtl/sic_div_cell.sv]
// one restoring division cell: one quotient bit per lane (x and y) per stage
module sic_div_cell #(
    parameter int DW = 34,
    parameter int QW = 18,
    parameter int SW = 40
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_vld,
    input  logic [DW-1:0]          i_d,
    input  logic [1:0][DW-1:0]     i_rem,
    input  logic [1:0][QW-1:0]     i_low,
    input  logic [1:0][QW-1:0]     i_quo,
    input  logic [SW-1:0]          i_side,
    output logic                   o_vld,
    output logic [DW-1:0]          o_d,
    output logic [1:0][DW-1:0]     o_rem,
    output logic [1:0][QW-1:0]     o_low,
    output logic [1:0][QW-1:0]     o_quo,
    output logic [SW-1:0]          o_side
);
    logic [1:0][DW-1:0] n_rem;
    logic [1:0][QW-1:0] n_low;
    logic [1:0][QW-1:0] n_quo;

    for (genvar k = 0; k < 2; k++) begin : g_lane
        logic [DW:0] trial;
        logic [DW:0] diff;
        logic        ge;
        assign trial = {i_rem[k], i_low[k][QW-1]};
        assign diff  = trial - {1'b0, i_d};
        assign ge    = (trial >= {1'b0, i_d});
        assign n_rem[k] = ge ? diff[DW-1:0] : trial[DW-1:0];
        assign n_low[k] = {i_low[k][QW-2:0], 1'b0};
        assign n_quo[k] = {i_quo[k][QW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_d    <= i_d;
            o_rem  <= n_rem;
            o_low  <= n_low;
            o_quo  <= n_quo;
            o_side <= i_side;
        end
    end
endmodule

[hw/rtl/segment_intersection_classifier_unit.sv]
// segment intersection classifier top level: cross products, classify, divider cell chain
//
//  channel  | dir | payload                                   | handshake
//  i_pair   | in  | a_x a_y b_x b_y c_x c_y d_x d_y           | valid/ready
//  o_result | out | relation cross_x cross_y point_clipped    | valid/ready
//
// one transaction per cycle sustained while the output is not stalled; the pipeline has
// six front stages, COORD_BITS + 2 divider cells and one output stage
// the divider cell chain (one quotient bit per cell) sets the latency
// reset clears every valid bit; data registers are not reset
// a stalled output holds the whole pipeline; ready is low only then
module segment_intersection_classifier_unit #(
    parameter int COORD_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sic_in_if.sink    i_pair,
    sic_out_if.source o_result
);
    localparam int N    = COORD_BITS;
    localparam int DIFW = N + 1;          // coordinate difference
    localparam int PRDW = 2 * N + 2;      // product of two differences
    localparam int NUMW = 2 * N + 3;      // num, den, numc
    localparam int MAGW = 2 * N + 2;      // magnitude of num / den
    localparam int DLW  = N + 1;          // magnitude of a delta
    localparam int PW   = MAGW + DLW;     // |num| * |delta|
    localparam int QW   = N + 2;          // quotient bits built by the cells
    localparam int VW   = N + 4;          // point before saturation
    localparam int SW   = 2 * N + 8;      // sideband through the cells

    logic en;
    logic r_out_vld;

    // the whole pipe moves unless the output register is full and stalled
    assign en           = !r_out_vld || o_result.ready;
    assign i_pair.ready = en;

    // stage 1: coordinate differences
    logic                   r1_vld;
    logic signed [DIFW-1:0] r1_acy, r1_acx, r1_dcx, r1_dcy, r1_bax, r1_bay;
    logic signed [N-1:0]    r1_ax, r1_ay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_pair.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_acy <= DIFW'(i_pair.a_y) - DIFW'(i_pair.c_y);
            r1_acx <= DIFW'(i_pair.a_x) - DIFW'(i_pair.c_x);
            r1_dcx <= DIFW'(i_pair.d_x) - DIFW'(i_pair.c_x);
            r1_dcy <= DIFW'(i_pair.d_y) - DIFW'(i_pair.c_y);
            r1_bax <= DIFW'(i_pair.b_x) - DIFW'(i_pair.a_x);
            r1_bay <= DIFW'(i_pair.b_y) - DIFW'(i_pair.a_y);
            r1_ax  <= i_pair.a_x;
            r1_ay  <= i_pair.a_y;
        end
    end

    // stage 2: six cross-product terms
    logic                   r2_vld;
    logic signed [PRDW-1:0] r2_p0, r2_p1, r2_p2, r2_p3, r2_p4, r2_p5;
    logic signed [DIFW-1:0] r2_bax, r2_bay;
    logic signed [N-1:0]    r2_ax, r2_ay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_p0  <= PRDW'(r1_acy) * PRDW'(r1_dcx);
            r2_p1  <= PRDW'(r1_acx) * PRDW'(r1_dcy);
            r2_p2  <= PRDW'(r1_bax) * PRDW'(r1_dcy);
            r2_p3  <= PRDW'(r1_bay) * PRDW'(r1_dcx);
            r2_p4  <= PRDW'(r1_acy) * PRDW'(r1_bax);
            r2_p5  <= PRDW'(r1_acx) * PRDW'(r1_bay);
            r2_bax <= r1_bax;
            r2_bay <= r1_bay;
            r2_ax  <= r1_ax;
            r2_ay  <= r1_ay;
        end
    end

    // stage 3: num, den, numc
    logic                   r3_vld;
    logic signed [NUMW-1:0] r3_num, r3_den, r3_numc;
    logic signed [DIFW-1:0] r3_bax, r3_bay;
    logic signed [N-1:0]    r3_ax, r3_ay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_num  <= NUMW'(r2_p0) - NUMW'(r2_p1);
            r3_den  <= NUMW'(r2_p2) - NUMW'(r2_p3);
            r3_numc <= NUMW'(r2_p4) - NUMW'(r2_p5);
            r3_bax  <= r2_bax;
            r3_bay  <= r2_bay;
            r3_ax   <= r2_ax;
            r3_ay   <= r2_ay;
        end
    end

    // stage 4: classify without dividing, take magnitudes and signs
    logic                n_ab_in, n_cd_in, n_den_zero;
    sic_pkg::t_relation  n_rel;
    logic [NUMW-1:0]     n_abs_num, n_abs_den;
    logic [DIFW-1:0]     n_abs_bax, n_abs_bay;

    always_comb begin
        n_den_zero = (r3_den == '0);
        if (r3_den > 0) begin
            n_ab_in = (r3_num >= 0) && (r3_num <= r3_den);
            n_cd_in = (r3_numc >= 0) && (r3_numc <= r3_den);
        end else begin
            n_ab_in = (r3_num <= 0) && (r3_num >= r3_den);
            n_cd_in = (r3_numc <= 0) && (r3_numc >= r3_den);
        end
        if (n_den_zero) begin
            n_rel = (r3_num == '0) ? sic_pkg::REL_COLLINEAR : sic_pkg::REL_PARALLEL;
        end else if (n_ab_in && n_cd_in) begin
            n_rel = sic_pkg::REL_SEGMENTS;
        end else if (n_cd_in) begin
            n_rel = sic_pkg::REL_CD_CROSSES;
        end else if (n_ab_in) begin
            n_rel = sic_pkg::REL_AB_CROSSES;
        end else begin
            n_rel = sic_pkg::REL_LINES_ONLY;
        end
        n_abs_num = r3_num[NUMW-1] ? -r3_num : r3_num;
        n_abs_den = r3_den[NUMW-1] ? -r3_den : r3_den;
        n_abs_bax = r3_bax[DIFW-1] ? -r3_bax : r3_bax;
        n_abs_bay = r3_bay[DIFW-1] ? -r3_bay : r3_bay;
    end

    logic                r4_vld;
    sic_pkg::t_relation  r4_rel;
    logic                r4_den_zero, r4_neg_x, r4_neg_y;
    logic [MAGW-1:0]     r4_mnum, r4_mden;
    logic [DLW-1:0]      r4_mbx, r4_mby;
    logic signed [N-1:0] r4_ax, r4_ay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (en) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_rel      <= n_rel;
            r4_den_zero <= n_den_zero;
            r4_neg_x    <= r3_num[NUMW-1] ^ r3_bax[DIFW-1] ^ r3_den[NUMW-1];
            r4_neg_y    <= r3_num[NUMW-1] ^ r3_bay[DIFW-1] ^ r3_den[NUMW-1];
            r4_mnum     <= n_abs_num[MAGW-1:0];
            r4_mden     <= n_abs_den[MAGW-1:0];
            r4_mbx      <= n_abs_bax;
            r4_mby      <= n_abs_bay;
            r4_ax       <= r3_ax;
            r4_ay       <= r3_ay;
        end
    end

    // stage 5: dividends |num| * |delta| per axis
    logic                r5_vld;
    sic_pkg::t_relation  r5_rel;
    logic                r5_den_zero, r5_neg_x, r5_neg_y;
    logic [PW-1:0]       r5_px, r5_py;
    logic [MAGW-1:0]     r5_mden;
    logic signed [N-1:0] r5_ax, r5_ay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (en) begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_rel      <= r4_rel;
            r5_den_zero <= r4_den_zero;
            r5_neg_x    <= r4_neg_x;
            r5_neg_y    <= r4_neg_y;
            r5_px       <= PW'(r4_mnum) * PW'(r4_mbx);
            r5_py       <= PW'(r4_mnum) * PW'(r4_mby);
            r5_mden     <= r4_mden;
            r5_ax       <= r4_ax;
            r5_ay       <= r4_ay;
        end
    end

    // stage 6: quotient overflow check and divider setup
    // a quotient of 2^QW or more always saturates the point, so only a flag is kept
    logic n_ovf_x, n_ovf_y;
    assign n_ovf_x = ({1'b0, r5_px[PW-1:QW]} >= r5_mden);
    assign n_ovf_y = ({1'b0, r5_py[PW-1:QW]} >= r5_mden);

    logic                      r6_vld;
    logic [MAGW-1:0]           r6_d;
    logic [1:0][MAGW-1:0]      r6_rem;
    logic [1:0][QW-1:0]        r6_low;
    logic [SW-1:0]             r6_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (en) begin
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // a zero divisor is kept away from the cells; the result is forced later
            r6_d      <= r5_den_zero ? MAGW'(1) : r5_mden;
            r6_rem[0] <= n_ovf_x ? '0 : {1'b0, r5_px[PW-1:QW]};
            r6_rem[1] <= n_ovf_y ? '0 : {1'b0, r5_py[PW-1:QW]};
            r6_low[0] <= r5_px[QW-1:0];
            r6_low[1] <= r5_py[QW-1:0];
            r6_side   <= {r5_rel, r5_den_zero, r5_neg_x, r5_neg_y,
                          n_ovf_x, n_ovf_y, r5_ax, r5_ay};
        end
    end

    // divider chain: cell i settles quotient bit QW-1-i
    logic [QW:0]               c_vld;
    logic [MAGW-1:0]           c_d    [QW+1];
    logic [1:0][MAGW-1:0]      c_rem  [QW+1];
    logic [1:0][QW-1:0]        c_low  [QW+1];
    logic [1:0][QW-1:0]        c_quo  [QW+1];
    logic [SW-1:0]             c_side [QW+1];

    assign c_vld[0]  = r6_vld;
    assign c_d[0]    = r6_d;
    assign c_rem[0]  = r6_rem;
    assign c_low[0]  = r6_low;
    assign c_quo[0]  = '0;
    assign c_side[0] = r6_side;

    for (genvar i = 0; i < QW; i++) begin : g_cell
        sic_div_cell #(
            .DW (MAGW),
            .QW (QW),
            .SW (SW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (c_vld[i]),
            .i_d     (c_d[i]),
            .i_rem   (c_rem[i]),
            .i_low   (c_low[i]),
            .i_quo   (c_quo[i]),
            .i_side  (c_side[i]),
            .o_vld   (c_vld[i+1]),
            .o_d     (c_d[i+1]),
            .o_rem   (c_rem[i+1]),
            .o_low   (c_low[i+1]),
            .o_quo   (c_quo[i+1]),
            .o_side  (c_side[i+1])
        );
    end

    // output stage: apply sign, add start point, saturate
    logic [2:0]          last_rel_code;
    sic_pkg::t_relation  last_rel;
    logic                last_den_zero, last_neg_x, last_neg_y, last_ovf_x, last_ovf_y;
    logic signed [N-1:0] last_ax, last_ay;
    logic [QW:0]         q_x, q_y;
    logic signed [VW-1:0] v_x, v_y;
    logic signed [N-1:0] s_x, s_y;
    logic                clip_x, clip_y;

    localparam logic signed [VW-1:0] MAXV = $signed({{5{1'b0}}, {(N-1){1'b1}}});
    localparam logic signed [VW-1:0] MINV = $signed({{5{1'b1}}, {(N-1){1'b0}}});

    assign {last_rel_code, last_den_zero, last_neg_x, last_neg_y, last_ovf_x, last_ovf_y,
            last_ax, last_ay} = c_side[QW];
    assign last_rel = sic_pkg::t_relation'(last_rel_code);

    always_comb begin
        q_x = last_ovf_x ? {1'b1, {QW{1'b0}}} : {1'b0, c_quo[QW][0]};
        q_y = last_ovf_y ? {1'b1, {QW{1'b0}}} : {1'b0, c_quo[QW][1]};
        v_x = last_neg_x ? VW'(last_ax) - $signed(VW'(q_x))
                         : VW'(last_ax) + $signed(VW'(q_x));
        v_y = last_neg_y ? VW'(last_ay) - $signed(VW'(q_y))
                         : VW'(last_ay) + $signed(VW'(q_y));
        clip_x = 1'b0;
        clip_y = 1'b0;
        s_x = v_x[N-1:0];
        s_y = v_y[N-1:0];
        if (v_x > MAXV) begin
            s_x = MAXV[N-1:0];
            clip_x = 1'b1;
        end else if (v_x < MINV) begin
            s_x = MINV[N-1:0];
            clip_x = 1'b1;
        end
        if (v_y > MAXV) begin
            s_y = MAXV[N-1:0];
            clip_y = 1'b1;
        end else if (v_y < MINV) begin
            s_y = MINV[N-1:0];
            clip_y = 1'b1;
        end
    end

    logic                r_out_clip;
    sic_pkg::t_relation  r_out_rel;
    logic signed [N-1:0] r_out_x, r_out_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= c_vld[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_rel  <= last_rel;
            // parallel and collinear lines carry no point
            r_out_x    <= last_den_zero ? '0 : s_x;
            r_out_y    <= last_den_zero ? '0 : s_y;
            r_out_clip <= last_den_zero ? 1'b0 : (clip_x | clip_y);
        end
    end

    assign o_result.valid         = r_out_vld;
    assign o_result.relation      = r_out_rel;
    assign o_result.cross_x       = r_out_x;
    assign o_result.cross_y       = r_out_y;
    assign o_result.point_clipped = r_out_clip;
endmodule
